// ===== rtl/lu_decompose_and_solve_macros.svh =====
// assertion macros for the lu solver
`ifndef LU_DECOMPOSE_AND_SOLVE_MACROS_SVH
`define LU_DECOMPOSE_AND_SOLVE_MACROS_SVH

// implication checked on every clock edge outside reset
`define LU_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define LU_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/lu_pkg.sv =====
// shared types, constants and arithmetic helpers for the lu solver
package lu_pkg;

    localparam int Dim      = 4;
    localparam int FracBits = 16;
    localparam int IdxW     = $clog2(Dim);
    localparam int AddrW    = $clog2(Dim * Dim);

    typedef struct packed {
        logic [1:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         index;
        logic signed [31:0] solution;
        logic signed [31:0] determinant;
        logic               singular;
        logic               final_res;
    } t_out_item;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_LOAD_A  = 3'd1,
        OP_LOAD_B  = 3'd2,
        OP_MAC     = 3'd3,
        OP_DIV     = 3'd4,
        OP_DET     = 3'd5,
        OP_ZERO    = 3'd6
    } t_op;

    // operand sources for multiply-subtract
    typedef enum logic [1:0] {
        SRC_MAT = 2'd0,
        SRC_RHS = 2'd1,
        SRC_SOL = 2'd2
    } t_src;

    typedef struct packed {
        t_op              op;
        logic [IdxW-1:0]  i;
        logic [IdxW-1:0]  j;
        logic [IdxW-1:0]  k;
        t_src             dst;       // where the accumulator is read and written
        logic             b_sol;     // second factor from solution store
        logic             init_acc;  // load accumulator from the destination
        logic             wr_acc;    // write accumulator back
        logic             div_go;
        logic             det_init;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic singular;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/lu_div.sv =====
// restoring fixed point divider, one quotient bit per cycle
module lu_div
    import lu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    localparam int NumW = 32 + FracBits;
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] r_q, n_q;
    logic [32:0]     r_rem, n_rem;
    logic [31:0]     r_den, n_den;
    logic            r_neg, n_neg;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [33:0]     w_trial;
    logic signed [NumW:0] w_sq;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_neg = r_neg;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem, r_q[NumW-1]} - {2'b0, r_den};
        if (i_go) begin
            n_q   = {(i_num[31] ? 32'(-i_num) : 32'(i_num)), {FracBits{1'b0}}};
            n_den = i_den[31] ? 32'(-i_den) : 32'(i_den);
            n_neg = i_num[31] ^ i_den[31];
            n_rem = '0;
            n_cnt = CntW'(NumW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[33]) begin
                n_rem = w_trial[32:0];
                n_q   = {r_q[NumW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_q[NumW-1]};
                n_q   = {r_q[NumW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_neg <= n_neg;
    end

    assign w_sq   = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign o_quot = sat32(66'(w_sq));
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule

// ===== rtl/lu_dp.sv =====
// datapath: matrix, rhs and solution stores, multiply-subtract unit, divider
module lu_dp
    import lu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  t_in_item        i_item,
    output t_stat           o_stat,
    output logic signed [31:0] o_sol,
    output logic signed [31:0] o_det
);
    logic signed [31:0] r_mat [Dim*Dim];
    logic signed [31:0] r_rhs [Dim];
    logic signed [31:0] r_sol [Dim];
    logic signed [31:0] r_acc, n_acc;
    logic signed [31:0] r_det, n_det;
    logic               r_sing, n_sing;
    logic signed [31:0] w_a, w_b, w_dst, w_prod;
    logic signed [63:0] w_full;
    logic signed [31:0] w_quot;
    logic               w_div_busy, w_div_done;
    logic               w_op_sub;

    function automatic logic [AddrW-1:0] adr(input logic [IdxW-1:0] r, input logic [IdxW-1:0] c);
        return AddrW'(r) * AddrW'(Dim) + AddrW'(c);
    endfunction

    always_comb begin
        unique case (i_cmd.dst)
            SRC_MAT: w_dst = r_mat[adr(i_cmd.i, i_cmd.j)];
            SRC_RHS: w_dst = r_rhs[i_cmd.i];
            default: w_dst = r_sol[i_cmd.i];
        endcase
        w_a = r_mat[adr(i_cmd.i, i_cmd.k)];
        w_b = i_cmd.b_sol ? r_sol[i_cmd.k] : r_mat[adr(i_cmd.k, i_cmd.j)];
        if (i_cmd.op == OP_DET) begin
            w_a = r_det;
            w_b = r_mat[adr(i_cmd.i, i_cmd.i)];
        end
    end

    // floor shift of the exact product
    assign w_full = w_a * w_b;
    assign w_prod = sat32(66'(w_full >>> FracBits));
    assign w_op_sub = (i_cmd.op == OP_MAC);

    lu_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (i_cmd.div_go),
        .i_num  (r_acc),
        .i_den  (r_mat[adr(i_cmd.j, i_cmd.j)]),
        .o_busy (w_div_busy),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_comb begin
        n_acc  = r_acc;
        n_det  = r_det;
        n_sing = r_sing;
        if (i_cmd.init_acc)  n_acc = w_dst;
        else if (w_op_sub)   n_acc = sat32(66'(r_acc) - 66'(w_prod));
        if (i_cmd.det_init) begin
            n_det  = 32'sd1 <<< FracBits;
            n_sing = 1'b0;
        end
        if (i_cmd.op == OP_DET) begin
            n_det = w_prod;
            if (w_b == 0) n_sing = 1'b1;
        end
        if (i_cmd.div_go && r_mat[adr(i_cmd.j, i_cmd.j)] == 0) n_sing = 1'b1;
        if (w_div_done) n_acc = (r_mat[adr(i_cmd.j, i_cmd.j)] == 0) ? 32'sd0 : w_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det  <= '0;
            r_sing <= 1'b0;
        end else begin
            r_det  <= n_det;
            r_sing <= n_sing;
        end
        r_acc <= n_acc;
        if (i_cmd.op == OP_LOAD_A) r_mat[adr(i_item.row, i_item.col[IdxW-1:0])] <= i_item.value;
        if (i_cmd.op == OP_LOAD_B) r_rhs[i_item.row] <= i_item.value;
        if (i_cmd.wr_acc) begin
            unique case (i_cmd.dst)
                SRC_MAT: r_mat[adr(i_cmd.i, i_cmd.j)] <= r_acc;
                SRC_RHS: r_rhs[i_cmd.i] <= r_acc;
                default: r_sol[i_cmd.i] <= r_acc;
            endcase
        end
    end

    assign o_stat.div_busy = w_div_busy | i_cmd.div_go;
    assign o_stat.singular = r_sing;
    assign o_sol = r_sing ? 32'sd0 : r_sol[i_cmd.k];
    assign o_det = r_sing ? 32'sd0 : r_det;
endmodule

// ===== rtl/lu_ctrl.sv =====
// controller: sequences load, factorization, determinant, substitution and output
module lu_ctrl
    import lu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  t_stat    i_stat,
    output logic     o_busy,
    output t_cmd     o_cmd,
    output logic     o_strobe,
    output logic     o_final
);
`include "lu_decompose_and_solve_macros.svh"

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_INIT  = 10'b0000000010,
        S_MAC   = 10'b0000000100,
        S_WB    = 10'b0000001000,
        S_DIVW  = 10'b0000010000,
        S_DET   = 10'b0000100000,
        S_FINIT = 10'b0001000000,
        S_FMAC  = 10'b0010000000,
        S_FWB   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    // phase inside the substitution states
    typedef enum logic [1:0] {
        PH_FWD = 2'd0,
        PH_BCK = 2'd1
    } t_phase;

    t_state          r_st, n_st;
    t_phase          r_ph, n_ph;
    logic [IdxW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic            r_div, n_div;   // current element needs a division
    logic            r_dgo, n_dgo;
    // remember which writeback issued the division
    logic            r_dbk, n_dbk;

    logic [IdxW:0] w_kend;

    always_comb begin
        // product count for element (i,j): min(i,j)
        w_kend = (r_i <= r_j) ? {1'b0, r_i} : {1'b0, r_j};
    end

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_i = r_i; n_j = r_j; n_k = r_k;
        n_div = r_div; n_dgo = 1'b0;
        o_cmd = '0;
        o_cmd.op = OP_NONE;
        o_cmd.dst = SRC_MAT;
        o_cmd.i = r_i; o_cmd.j = r_j; o_cmd.k = r_k;
        o_strobe = 1'b0;
        o_final  = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    if ({1'b0, i_item.col} < 4'(Dim)) o_cmd.op = OP_LOAD_A;
                    else if (32'(i_item.col) == Dim) o_cmd.op = OP_LOAD_B;
                    if (i_item.last) begin
                        n_st = S_INIT; n_i = '0; n_j = '0; n_k = '0;
                    end
                end
            end
            // factor element (i,j), column by column
            S_INIT: begin
                o_cmd.init_acc = 1'b1;
                n_k = '0;
                n_div = r_i > r_j;
                n_st = (w_kend == '0) ? S_WB : S_MAC;
            end
            S_MAC: begin
                o_cmd.op = OP_MAC;
                n_k = r_k + 1'b1;
                if ({1'b0, r_k} + 1'b1 == w_kend) n_st = S_WB;
            end
            S_WB: begin
                if (r_div) begin
                    o_cmd.div_go = 1'b1;
                    n_div = 1'b0;
                    n_st = S_DIVW;
                end else begin
                    o_cmd.wr_acc = 1'b1;
                    if (r_i == IdxW'(Dim - 1)) begin
                        n_i = '0;
                        if (r_j == IdxW'(Dim - 1)) begin
                            n_st = S_DET;
                            o_cmd.det_init = 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                            n_st = S_INIT;
                        end
                    end else begin
                        n_i = r_i + 1'b1;
                        n_st = S_INIT;
                    end
                end
            end
            S_DIVW: begin
                if (!i_stat.div_busy && !r_dgo) n_st = S_WB;
                n_dgo = 1'b0;
            end
            S_DET: begin
                o_cmd.op = OP_DET;
                n_i = r_i + 1'b1;
                if (r_i == IdxW'(Dim - 1)) begin
                    n_i = '0; n_ph = PH_FWD; n_st = S_FINIT;
                end
            end
            // substitution: row i, forward then backward
            S_FINIT: begin
                o_cmd.init_acc = 1'b1;
                o_cmd.dst = (r_ph == PH_FWD) ? SRC_RHS : SRC_SOL;
                n_k = (r_ph == PH_FWD) ? '0 : r_i + 1'b1;
                if (r_ph == PH_FWD) n_st = (r_i == '0) ? S_FWB : S_FMAC;
                else n_st = (r_i == IdxW'(Dim - 1)) ? S_FWB : S_FMAC;
            end
            S_FMAC: begin
                o_cmd.op = OP_MAC;
                o_cmd.b_sol = 1'b1;
                o_cmd.j = r_k;
                n_k = r_k + 1'b1;
                if (r_ph == PH_FWD) begin
                    if (r_k + 1'b1 == r_i) n_st = S_FWB;
                end else if (r_k == IdxW'(Dim - 1)) n_st = S_FWB;
            end
            S_FWB: begin
                o_cmd.dst = SRC_SOL;
                o_cmd.j = r_i;
                if (r_ph == PH_BCK && r_div) begin
                    o_cmd.div_go = 1'b1;
                    n_div = 1'b0;
                    n_st = S_DIVW;
                end else begin
                    o_cmd.wr_acc = 1'b1;
                    n_div = 1'b1;
                    n_st = S_FINIT;
                    if (r_ph == PH_FWD) begin
                        if (r_i == IdxW'(Dim - 1)) n_ph = PH_BCK;
                        else n_i = r_i + 1'b1;
                    end else if (r_i == '0) begin
                        n_st = S_OUT; n_k = '0;
                    end else n_i = r_i - 1'b1;
                    if (n_st == S_FINIT) n_div = 1'b1;
                end
            end
            S_OUT: begin
                o_strobe = 1'b1;
                o_final = (r_k == IdxW'(Dim - 1));
                n_k = r_k + 1'b1;
                if (o_final) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
        // divider return goes to the element's writeback state
        if (r_st == S_DIVW && n_st == S_WB && r_ph == PH_BCK && r_j == r_i && r_dbk)
            n_st = S_FWB;
        if (o_cmd.div_go) n_dgo = 1'b1;
    end

    always_comb begin
        n_dbk = r_dbk;
        if (r_st == S_WB && o_cmd.div_go)  n_dbk = 1'b0;
        if (r_st == S_FWB && o_cmd.div_go) n_dbk = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ph <= PH_FWD;
            r_i <= '0; r_j <= '0; r_k <= '0;
            r_div <= 1'b0; r_dgo <= 1'b0; r_dbk <= 1'b0;
        end else begin
            r_st <= n_st; r_ph <= n_ph;
            r_i <= n_i; r_j <= (n_st == S_FWB || n_st == S_DIVW && n_dbk) ? n_i : n_j;
            r_k <= n_k;
            r_div <= n_div; r_dgo <= n_dgo; r_dbk <= n_dbk;
        end
    end

    assign o_busy = (r_st != S_IDLE);

    `LU_ASSERT_IMP(a_strobe_out, i_clk, i_rst_n, o_strobe, r_st == S_OUT)
    `LU_ASSERT_NXT(a_final_idle, i_clk, i_rst_n, o_final, r_st == S_IDLE)
    `LU_ASSERT_IMP(a_div_wait, i_clk, i_rst_n, o_cmd.div_go, r_st == S_WB || r_st == S_FWB)
endmodule

// ===== rtl/lu_decompose_and_solve.sv =====
// top level of the lu factorization and linear solver
// Loads a 4x4 Q16.16 matrix and right-hand side (col 4), one beat per cycle
// while busy is low. The beat marked last starts a Doolittle factorization
// without pivoting and forward/back substitution; busy then stays high
// until the last result beat is out. The work uses one shared
// multiply-subtract unit (one product a cycle, held while a division runs)
// and a bit-serial divider that yields 48 quotient bits for each of the
// 10 divisions. Four result beats follow on consecutive cycles, one per
// solution entry, each with the determinant; they close the busy period
// and cannot be stalled.
module lu_decompose_and_solve
    import lu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_item
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_final;
    logic signed [31:0] w_sol, w_det;

    lu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd),
        .o_strobe(o_strobe),
        .o_final (w_final)
    );

    lu_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_item (i_item),
        .o_stat (w_stat),
        .o_sol  (w_sol),
        .o_det  (w_det)
    );

    assign o_item.index       = 2'(w_cmd.k);
    assign o_item.solution    = w_sol;
    assign o_item.determinant = w_det;
    assign o_item.singular    = w_stat.singular;
    assign o_item.final_res   = w_final;
endmodule
